### sv/aic_pkg.sv
package aic_pkg;

  localparam int NUM_UP        = 4;
  localparam int NUM_DOWN      = 4;
  localparam int PENDING_DEPTH = 16;
  localparam int ADDR_WIDTH    = 48;
  localparam int SHIFT_W       = 6;
  localparam int SHIFT_RESET   = 12;

  localparam int UP_BITS    = $clog2(NUM_UP);
  localparam int DOWN_BITS  = $clog2(NUM_DOWN);
  localparam int PTR_BITS   = $clog2(PENDING_DEPTH);
  localparam int CNT_BITS   = $clog2(PENDING_DEPTH + 1);
  localparam int ADDR_IDX_W = $clog2(ADDR_WIDTH);

  typedef struct packed {
    logic [3:0]            up_req_valid;
    logic [ADDR_WIDTH-1:0] up0_addr;
    logic [ADDR_WIDTH-1:0] up1_addr;
    logic [ADDR_WIDTH-1:0] up2_addr;
    logic [ADDR_WIDTH-1:0] up3_addr;
    logic [3:0]            down_req_ready;
    logic [3:0]            down_resp_valid;
    logic [3:0]            up_resp_ready;
  } in_t;

  typedef struct packed {
    logic [3:0] up_req_take;
    logic [3:0] down_req_send;
    logic [7:0] down_req_from;
    logic [3:0] down_resp_take;
    logic [3:0] up_resp_send;
    logic [7:0] up_resp_from;
  } out_t;

  // controls driven into one target lane
  typedef struct packed {
    logic              adv;
    logic              resp_valid;
    logic              req_ready;
    logic [NUM_UP-1:0] up_ready;
    logic [NUM_UP-1:0] req_hit;
  } lane_in_t;

  // what one target lane found this cycle
  typedef struct packed {
    logic               elig;
    logic [UP_BITS-1:0] head_src;
    logic               send;
    logic [UP_BITS-1:0] from;
  } lane_stat_t;

  // target select: address bits [shift +: DOWN_BITS], zero above the address width
  function automatic logic [DOWN_BITS-1:0] route_of(logic [ADDR_WIDTH-1:0] addr,
                                                    logic [SHIFT_W-1:0] shift);
    logic [DOWN_BITS-1:0] r;
    logic [SHIFT_W:0]     pos;
    r = '0;
    for (int k = 0; k < DOWN_BITS; k++) begin
      pos = {1'b0, shift} + (SHIFT_W+1)'(k);
      if (pos < (SHIFT_W+1)'(ADDR_WIDTH)) begin
        r[k] = addr[pos[ADDR_IDX_W-1:0]];
      end
    end
    return r;
  endfunction

endpackage

### sv/address_interleaved_crossbar_unit.sv
// Each result is registered in the output register, or in the skid on a stall.
// Throughput: one item per cycle while in_stall is low; each cycle's arbitration and queue update
// complete in one pass over the per-target lanes and the merge stage.
// A two-entry output buffer takes one more input transfer while a result is stalled.
// Reset (synchronous, rst_n low) empties all pending queues, drops buffered
// results and sets the interleave shift to 12; queue entries need no clearing.
module address_interleaved_crossbar_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  aic_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output aic_pkg::out_t               out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [aic_pkg::SHIFT_W-1:0] cfg_data
);

  logic [aic_pkg::SHIFT_W-1:0]    shift_r;
  logic                           adv;
  logic [aic_pkg::ADDR_WIDTH-1:0] addr [aic_pkg::NUM_UP];
  logic [aic_pkg::DOWN_BITS-1:0]  route [aic_pkg::NUM_UP];
  aic_pkg::lane_in_t              lane_ctl [aic_pkg::NUM_DOWN];
  aic_pkg::lane_stat_t            lane_stat [aic_pkg::NUM_DOWN];
  logic [aic_pkg::NUM_DOWN-1:0]   pop;
  aic_pkg::out_t                  res;

  logic                           out_valid_r, skid_valid_r;
  aic_pkg::out_t                  out_data_r, skid_data_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= aic_pkg::SHIFT_W'(aic_pkg::SHIFT_RESET);
    end else if (cfg_valid) begin
      shift_r <= cfg_data;
    end
  end

  assign in_stall = skid_valid_r;
  assign adv      = in_valid && !in_stall;

  assign addr[0] = in_data.up0_addr;
  assign addr[1] = in_data.up1_addr;
  assign addr[2] = in_data.up2_addr;
  assign addr[3] = in_data.up3_addr;

  always_comb begin
    for (int i = 0; i < aic_pkg::NUM_UP; i++) begin
      route[i] = aic_pkg::route_of(addr[i], shift_r);
    end
  end

  always_comb begin
    for (int t = 0; t < aic_pkg::NUM_DOWN; t++) begin
      lane_ctl[t].adv        = adv;
      lane_ctl[t].resp_valid = in_data.down_resp_valid[t];
      lane_ctl[t].req_ready  = in_data.down_req_ready[t];
      lane_ctl[t].up_ready   = in_data.up_resp_ready;
      for (int i = 0; i < aic_pkg::NUM_UP; i++) begin
        lane_ctl[t].req_hit[i] = in_data.up_req_valid[i] &&
                                 (route[i] == aic_pkg::DOWN_BITS'(t));
      end
    end
  end

  for (genvar t = 0; t < aic_pkg::NUM_DOWN; t++) begin : g_lane
    aic_lane u_lane (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl  (lane_ctl[t]),
      .pop  (pop[t]),
      .stat (lane_stat[t])
    );
  end

  aic_merge u_merge (
    .stat(lane_stat),
    .pop (pop),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      // output slot free or leaving: refill from skid first, else from this cycle
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= adv;
      end
    end else if (adv) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end else if (adv) begin
      skid_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while the output slot is empty");

  a_skid_catch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall && adv |=> skid_valid_r && out_valid_r)
    else $error("transfer during output stall was not held in the skid");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

endmodule

### sv/aic_lane.sv
module aic_lane (
  input  logic                  clk,
  input  logic                  rst_n,
  input  aic_pkg::lane_in_t     ctl,
  input  logic                  pop,
  output aic_pkg::lane_stat_t   stat
);

  logic [aic_pkg::UP_BITS-1:0]  src_r [aic_pkg::PENDING_DEPTH];
  logic [aic_pkg::PTR_BITS-1:0] head_r, head_nxt;
  logic [aic_pkg::CNT_BITS-1:0] count_r, count_nxt, count_after;
  logic [aic_pkg::PTR_BITS-1:0] slot;
  logic                         any_req, full, push;
  logic [aic_pkg::UP_BITS-1:0]  pick;

  assign stat.head_src = src_r[head_r];
  assign stat.elig = ctl.resp_valid && (count_r != '0) && ctl.up_ready[stat.head_src];

  // the pop of this cycle frees space before the fullness check
  assign count_after = count_r - aic_pkg::CNT_BITS'(pop);
  assign full        = (count_after == aic_pkg::CNT_BITS'(aic_pkg::PENDING_DEPTH));

  // lowest requester index routed here wins
  always_comb begin
    any_req = 1'b0;
    pick    = '0;
    for (int i = aic_pkg::NUM_UP - 1; i >= 0; i--) begin
      if (ctl.req_hit[i]) begin
        any_req = 1'b1;
        pick    = aic_pkg::UP_BITS'(i);
      end
    end
  end

  assign push      = any_req && ctl.req_ready && !full;
  assign stat.send = push;
  assign stat.from = push ? pick : '0;

  assign slot      = head_r + count_r[aic_pkg::PTR_BITS-1:0];
  assign head_nxt  = pop ? head_r + 1'b1 : head_r;
  assign count_nxt = count_after + aic_pkg::CNT_BITS'(push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (ctl.adv) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv && push) begin
      src_r[slot] <= pick;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= aic_pkg::CNT_BITS'(aic_pkg::PENDING_DEPTH))
    else $error("pending count above depth");

  a_pop_elig: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> stat.elig)
    else $error("pop of a lane without an eligible response");

  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.adv && push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("push did not grow the queue");

endmodule

### sv/aic_merge.sv
module aic_merge (
  input  aic_pkg::lane_stat_t          stat [aic_pkg::NUM_DOWN],
  output logic [aic_pkg::NUM_DOWN-1:0] pop,
  output aic_pkg::out_t                res
);

  logic [aic_pkg::NUM_DOWN-1:0] blocked;

  // earlier target with the same head requester takes precedence
  always_comb begin
    blocked = '0;
    for (int t = 0; t < aic_pkg::NUM_DOWN; t++) begin
      for (int p = 0; p < t; p++) begin
        if (stat[p].elig && (stat[p].head_src == stat[t].head_src)) begin
          blocked[t] = 1'b1;
        end
      end
      pop[t] = stat[t].elig && !blocked[t];
    end
  end

  always_comb begin
    res = '0;
    for (int t = 0; t < aic_pkg::NUM_DOWN; t++) begin
      res.down_resp_take[t] = pop[t];
      res.down_req_send[t]  = stat[t].send;
      res.down_req_from[t*aic_pkg::UP_BITS +: aic_pkg::UP_BITS] = stat[t].from;
      if (pop[t]) begin
        res.up_resp_send[stat[t].head_src] = 1'b1;
        res.up_resp_from[stat[t].head_src*aic_pkg::DOWN_BITS +: aic_pkg::DOWN_BITS] =
          aic_pkg::DOWN_BITS'(t);
      end
      if (stat[t].send) begin
        res.up_req_take[stat[t].from] = 1'b1;
      end
    end
  end

endmodule
